// File: design/battery_cell_scan_monitor_defines.svh
// ----------------------------------------------------------------------------
// battery cell scan monitor assertion macros
// shared check macros; they expect clk and arst_n in the enclosing scope
// ----------------------------------------------------------------------------
`ifndef BATTERY_CELL_SCAN_MONITOR_DEFINES_SVH
`define BATTERY_CELL_SCAN_MONITOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BCSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BCSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bcsm_pkg.sv
// ----------------------------------------------------------------------------
// bcsm_pkg
// shared widths, register map, scan step codes and types of the cell monitor
// ----------------------------------------------------------------------------
`default_nettype none

package bcsm_pkg;

	// field widths
	localparam int MV_W     = 13;
	localparam int HALF_W   = 7;
	localparam int PCT_W    = 7;
	localparam int RELAY_W  = 4;
	localparam int CELL_W   = 2;
	localparam int LEVEL_W  = 2;
	localparam int STEP_W   = 3;
	localparam int NCELLS   = 4;

	// percentage divider: numerator is 100 times a millivolt difference
	localparam int NUM_W    = 20;
	localparam int DCNT_W   = 3;

	// configuration port
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// register indexes
	localparam logic [1:0] REG_FULL     = 2'd0;
	localparam logic [1:0] REG_EMPTY    = 2'd1;
	localparam logic [1:0] REG_CRITICAL = 2'd2;
	localparam logic [1:0] REG_UNREAL   = 2'd3;

	// register reset values, millivolts
	localparam logic [MV_W-1:0] FULL_RST     = 13'd4210;
	localparam logic [MV_W-1:0] EMPTY_RST    = 13'd3700;
	localparam logic [MV_W-1:0] CRITICAL_RST = 13'd3650;
	localparam logic [MV_W-1:0] UNREAL_RST   = 13'd3000;
	localparam logic [MV_W-1:0] STORE_RST    = 13'd4210;

	// scan step codes
	localparam logic [STEP_W-1:0] STEP_SELECT = 3'd0;
	localparam logic [STEP_W-1:0] STEP_SETTLE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_START  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd4;
	localparam logic [STEP_W-1:0] STEP_READ   = 3'd5;

	// alarm levels
	localparam logic [LEVEL_W-1:0] ALARM_NONE   = 2'd0;
	localparam logic [LEVEL_W-1:0] ALARM_CRIT   = 2'd1;
	localparam logic [LEVEL_W-1:0] ALARM_UNREAL = 2'd2;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

	// thresholds as seen by the datapath
	typedef struct packed {
		logic [MV_W-1:0] full_mv;
		logic [MV_W-1:0] empty_mv;
		logic [MV_W-1:0] critical_mv;
		logic [MV_W-1:0] unreal_mv;
	} cfg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: design/bcsm_tick_if.sv
// ----------------------------------------------------------------------------
// bcsm_tick_if
// tick channel: converter status and sample, one item per scan tick
// ----------------------------------------------------------------------------
`default_nettype none

interface bcsm_tick_if;
	logic                        valid;
	logic                        ready;
	logic                        adc_done;
	logic [bcsm_pkg::MV_W-1:0]   adc_mv;

	modport source (output valid, output adc_done, output adc_mv, input ready);
	modport sink   (input valid, input adc_done, input adc_mv, output ready);
endinterface

`default_nettype wire

// File: design/bcsm_report_if.sv
// ----------------------------------------------------------------------------
// bcsm_report_if
// report channel: relay drive, reading and alarm status, one item per tick
// ----------------------------------------------------------------------------
`default_nettype none

interface bcsm_report_if;
	logic                          valid;
	logic                          ready;
	logic [bcsm_pkg::RELAY_W-1:0]  relay_select;
	logic                          adc_start;
	logic                          reading_valid;
	logic [bcsm_pkg::CELL_W-1:0]   cell_index;
	logic [bcsm_pkg::HALF_W-1:0]   mv_low_half;
	logic [bcsm_pkg::HALF_W-1:0]   mv_high_half;
	logic [bcsm_pkg::PCT_W-1:0]    charge_percent;
	logic [bcsm_pkg::LEVEL_W-1:0]  alarm_level;
	logic                          recovery_chirp;

	modport source (output valid, output relay_select, output adc_start,
		output reading_valid, output cell_index, output mv_low_half,
		output mv_high_half, output charge_percent, output alarm_level,
		output recovery_chirp, input ready);
	modport sink (input valid, input relay_select, input adc_start,
		input reading_valid, input cell_index, input mv_low_half,
		input mv_high_half, input charge_percent, input alarm_level,
		input recovery_chirp, output ready);
endinterface

`default_nettype wire

// File: design/battery_cell_scan_monitor.sv
// ----------------------------------------------------------------------------
// battery_cell_scan_monitor
// four-cell scan sequencer with charge percentage and alarm reporting
// ----------------------------------------------------------------------------
// Usage:
// Each item on the tick channel is one scan tick carrying the converter's
// done flag and its millivolt sample. For every tick the block returns one
// item on the report channel: relay drive, converter start, reading and
// charge percentage on the read step, alarm level and recovery chirp.
// The user must write thresholds through the APB-style port only while the
// block idles; the block itself does not enforce this. A tick that is not a
// read step passes from the pending item register into the report register.
// A read step whose sample lies between the empty and full thresholds first
// runs the bit-serial divider for its seven quotient bits. A new tick is
// taken once the previous one has been placed in the output register.
// A full report register holds its item until the receiver takes it; the
// next tick may still be accepted in the meantime and waits in the
// sequencer. Reset returns the scan to cell 0 step 0, fills all stored cell
// voltages with 4210 mV, loads the default thresholds and arms the chirp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "battery_cell_scan_monitor_defines.svh"

module battery_cell_scan_monitor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bcsm_tick_if.sink                          tick,
	bcsm_report_if.source                      report,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcsm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bcsm_pkg::DATA_W-1:0]   pwdata,
	output logic      [bcsm_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);

	bcsm_pkg::cfg_t   cfg;
	bcsm_pkg::state_t state_q, state_d;

	// scan state
	logic [bcsm_pkg::STEP_W-1:0] scan_step_q;
	logic [bcsm_pkg::CELL_W-1:0] cell_q;
	logic [bcsm_pkg::MV_W-1:0]   store_q [bcsm_pkg::NCELLS];
	logic                        alarm_was_q;

	// pending item
	logic [bcsm_pkg::CELL_W-1:0] cell_s1;
	logic                        start_s1;
	logic                        rd_s1;
	logic [bcsm_pkg::MV_W-1:0]   mv_s1;
	logic [bcsm_pkg::PCT_W-1:0]  pct_s1;

	// report register
	logic                         out_valid_q;
	logic [bcsm_pkg::RELAY_W-1:0] relay_s2;
	logic                         start_s2;
	logic                         rd_s2;
	logic [bcsm_pkg::CELL_W-1:0]  cell_s2;
	logic [bcsm_pkg::HALF_W-1:0]  lo_s2;
	logic [bcsm_pkg::HALF_W-1:0]  hi_s2;
	logic [bcsm_pkg::PCT_W-1:0]   pct_s2;
	logic [bcsm_pkg::LEVEL_W-1:0] level_s2;
	logic                         chirp_s2;

	logic                         accept;
	logic                         emit;
	logic [bcsm_pkg::STEP_W-1:0]  nstep;
	logic                         wrap_c;
	logic                         start_c;
	logic                         rd_c;
	logic                         low_c;
	logic                         high_c;
	logic                         div_go;
	logic [bcsm_pkg::MV_W-1:0]    diff_c;
	logic [bcsm_pkg::NUM_W-1:0]   num_c;
	logic [bcsm_pkg::MV_W-1:0]    den_c;
	logic                         div_busy;
	logic                         div_done;
	logic [bcsm_pkg::PCT_W-1:0]   div_quot;
	logic                         crit_c;
	logic                         unreal_c;
	logic [bcsm_pkg::LEVEL_W-1:0] level_c;

	bcsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (num_c),
		.den    (den_c),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign tick.ready = (state_q == bcsm_pkg::ST_IDLE);
	assign accept     = tick.valid & tick.ready;

	// next scan step and per-step actions
	always_comb begin
		nstep   = scan_step_q + 1'b1;
		start_c = 1'b0;
		rd_c    = 1'b0;
		unique case (scan_step_q)
			bcsm_pkg::STEP_START: start_c = 1'b1;
			bcsm_pkg::STEP_WAIT: begin
				if (!tick.adc_done) nstep = bcsm_pkg::STEP_WAIT;
			end
			bcsm_pkg::STEP_READ:  rd_c = 1'b1;
			default: ;
		endcase
		// stray codes above the read step behave like the select step
		if (scan_step_q > bcsm_pkg::STEP_READ) nstep = bcsm_pkg::STEP_SETTLE;
		wrap_c = (nstep > bcsm_pkg::STEP_READ);
		if (wrap_c) nstep = bcsm_pkg::STEP_SELECT;
	end

	// percentage operands: 100 * (mv - empty) by shift and add
	assign low_c  = (tick.adc_mv <= cfg.empty_mv);
	assign high_c = (tick.adc_mv >= cfg.full_mv);
	assign diff_c = tick.adc_mv - cfg.empty_mv;
	assign den_c  = cfg.full_mv - cfg.empty_mv;
	assign num_c  = (bcsm_pkg::NUM_W'(diff_c) << 6) + (bcsm_pkg::NUM_W'(diff_c) << 5)
		+ (bcsm_pkg::NUM_W'(diff_c) << 2);
	assign div_go = accept & rd_c & ~low_c & ~high_c;

	// alarm over the stored voltages
	always_comb begin
		crit_c   = 1'b0;
		unreal_c = 1'b0;
		for (int k = 0; k < bcsm_pkg::NCELLS; k++) begin
			if (store_q[k] <= cfg.critical_mv) crit_c = 1'b1;
			if (store_q[k] <= cfg.unreal_mv) unreal_c = 1'b1;
		end
		if (!crit_c)       level_c = bcsm_pkg::ALARM_NONE;
		else if (unreal_c) level_c = bcsm_pkg::ALARM_UNREAL;
		else               level_c = bcsm_pkg::ALARM_CRIT;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		unique case (state_q)
			bcsm_pkg::ST_IDLE: begin
				if (accept) state_d = div_go ? bcsm_pkg::ST_DIV : bcsm_pkg::ST_EMIT;
			end
			bcsm_pkg::ST_DIV: begin
				if (div_done) state_d = bcsm_pkg::ST_EMIT;
			end
			bcsm_pkg::ST_EMIT: begin
				if (!out_valid_q || report.ready) begin
					emit    = 1'b1;
					state_d = bcsm_pkg::ST_IDLE;
				end
			end
			default: state_d = bcsm_pkg::ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcsm_pkg::ST_IDLE;
			scan_step_q <= bcsm_pkg::STEP_SELECT;
			cell_q      <= '0;
			alarm_was_q <= 1'b1;
			out_valid_q <= 1'b0;
			for (int k = 0; k < bcsm_pkg::NCELLS; k++) begin
				store_q[k] <= bcsm_pkg::STORE_RST;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_step_q <= nstep;
				if (wrap_c) cell_q <= cell_q + 1'b1;
				if (rd_c) store_q[cell_q] <= tick.adc_mv;
			end
			// the alarm memory follows the critical flag of each report
			if (emit) alarm_was_q <= crit_c;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending item capture, the empty clamp wins over the full clamp
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1  <= cell_q;
			start_s1 <= start_c;
			rd_s1    <= rd_c;
			mv_s1    <= rd_c ? tick.adc_mv : '0;
			pct_s1   <= (rd_c && high_c && !low_c) ? bcsm_pkg::PCT_FULL : bcsm_pkg::PCT_NONE;
		end else if (state_q == bcsm_pkg::ST_DIV && div_done) begin
			pct_s1 <= div_quot;
		end
	end

	// report register
	always_ff @(posedge clk) begin
		if (emit) begin
			relay_s2 <= bcsm_pkg::RELAY_W'(1) << cell_s1;
			start_s2 <= start_s1;
			rd_s2    <= rd_s1;
			cell_s2  <= cell_s1;
			lo_s2    <= mv_s1[bcsm_pkg::HALF_W-1:0];
			hi_s2    <= bcsm_pkg::HALF_W'(mv_s1 >> bcsm_pkg::HALF_W);
			pct_s2   <= pct_s1;
			level_s2 <= level_c;
			chirp_s2 <= ~crit_c & alarm_was_q;
		end
	end

	assign report.valid          = out_valid_q;
	assign report.relay_select   = relay_s2;
	assign report.adc_start      = start_s2;
	assign report.reading_valid  = rd_s2;
	assign report.cell_index     = cell_s2;
	assign report.mv_low_half    = lo_s2;
	assign report.mv_high_half   = hi_s2;
	assign report.charge_percent = pct_s2;
	assign report.alarm_level    = level_s2;
	assign report.recovery_chirp = chirp_s2;

	// checks
	`BCSM_ASSERT_NOW(a_div_running, state_q == bcsm_pkg::ST_DIV, div_busy || div_done, "waiting on an idle divider")
	`BCSM_ASSERT_NOW(a_chirp_no_alarm, report.valid && report.recovery_chirp, report.alarm_level == bcsm_pkg::ALARM_NONE, "chirp with alarm raised")
	`BCSM_ASSERT_NOW(a_pct_range, report.valid, report.charge_percent <= bcsm_pkg::PCT_FULL, "percentage above full")
	`BCSM_ASSERT_NEXT(a_div_to_emit, state_q == bcsm_pkg::ST_DIV && div_done, state_q == bcsm_pkg::ST_EMIT, "divider result not taken")

endmodule

`default_nettype wire

// File: design/bcsm_cfg.sv
// ----------------------------------------------------------------------------
// bcsm_cfg
// threshold register bank behind a zero wait state APB-style port
// ----------------------------------------------------------------------------
`default_nettype none

module bcsm_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcsm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bcsm_pkg::DATA_W-1:0]   pwdata,
	output logic      [bcsm_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	output bcsm_pkg::cfg_t                     cfg
);

	bcsm_pkg::cfg_t      cfg_q;
	logic                wr_en;
	logic [1:0]          reg_idx;
	logic [bcsm_pkg::MV_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_mv     <= bcsm_pkg::FULL_RST;
			cfg_q.empty_mv    <= bcsm_pkg::EMPTY_RST;
			cfg_q.critical_mv <= bcsm_pkg::CRITICAL_RST;
			cfg_q.unreal_mv   <= bcsm_pkg::UNREAL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				bcsm_pkg::REG_FULL:     cfg_q.full_mv     <= pwdata[bcsm_pkg::MV_W-1:0];
				bcsm_pkg::REG_EMPTY:    cfg_q.empty_mv    <= pwdata[bcsm_pkg::MV_W-1:0];
				bcsm_pkg::REG_CRITICAL: cfg_q.critical_mv <= pwdata[bcsm_pkg::MV_W-1:0];
				bcsm_pkg::REG_UNREAL:   cfg_q.unreal_mv   <= pwdata[bcsm_pkg::MV_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			bcsm_pkg::REG_FULL:     rd_val = cfg_q.full_mv;
			bcsm_pkg::REG_EMPTY:    rd_val = cfg_q.empty_mv;
			bcsm_pkg::REG_CRITICAL: rd_val = cfg_q.critical_mv;
			bcsm_pkg::REG_UNREAL:   rd_val = cfg_q.unreal_mv;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = bcsm_pkg::DATA_W'(rd_val);

endmodule

`default_nettype wire

// File: design/bcsm_div.sv
// ----------------------------------------------------------------------------
// bcsm_div
// bit-serial restoring divider, one quotient bit per cycle, for the percentage
// ----------------------------------------------------------------------------
`default_nettype none

module bcsm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [bcsm_pkg::NUM_W-1:0]    num,
	input  wire logic [bcsm_pkg::MV_W-1:0]     den,
	output logic                               busy,
	output logic                               done,
	output logic      [bcsm_pkg::PCT_W-1:0]    quot
);

	logic [bcsm_pkg::NUM_W-1:0]  rem_q;
	logic [bcsm_pkg::NUM_W-1:0]  dsh_q;
	logic [bcsm_pkg::PCT_W-1:0]  quot_q;
	logic [bcsm_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        fits;

	// trial subtract of the shifted divisor
	assign fits = (rem_q >= dsh_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= bcsm_pkg::DCNT_W'(bcsm_pkg::PCT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: quotient shifts in msb first, divisor shifts right
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= bcsm_pkg::NUM_W'(den) << (bcsm_pkg::PCT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[bcsm_pkg::PCT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire
